/* rtl/core/tlt_pkg.sv */
// Shared constants, types and the arctangent table for the tilt angle pipeline.
package tlt_pkg;

    // Default sample width and number of CORDIC iterations
    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    // Operands are aligned so the magnitude MSB sits at bit 39
    localparam int ALIGN_BITS   = 40;
    // X/Y datapath: 2^39 magnitude, CORDIC gain and sqrt(2) growth, plus sign
    localparam int CW           = 43;
    // Angle accumulator in 1/65536 degree, sum of table fits in 24 bits + sign
    localparam int ZW           = 25;
    // Result angle width, 1/64 degree
    localparam int AW           = 15;
    // Angle after dropping the 10 fraction bits of the accumulator
    localparam int RW           = ZW - 10;

    localparam logic [AW-1:0]        QUARTER_TURN = AW'(5760);
    localparam logic signed [ZW-1:0] ROUND_HALF   = ZW'(512);

    // Quadrant codes
    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;
    localparam logic [1:0] QUAD_FOURTH = 2'd3;

    // One transaction moving down the CORDIC stages
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic [1:0]           quad;
        logic                 num_zero;   // numerator is zero: angle 0
        logic                 den_zero;   // denominator is zero: angle 90 deg
    } cordic_t;

    // atan(2^-i) in 1/65536 degree, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_step(input int unsigned i);
        logic signed [ZW-1:0] t;
        case (i)
            0:       t = 25'sd2949120;
            1:       t = 25'sd1740967;
            2:       t = 25'sd919879;
            3:       t = 25'sd466945;
            4:       t = 25'sd234379;
            5:       t = 25'sd117304;
            6:       t = 25'sd58666;
            7:       t = 25'sd29335;
            8:       t = 25'sd14668;
            9:       t = 25'sd7334;
            10:      t = 25'sd3667;
            11:      t = 25'sd1833;
            12:      t = 25'sd917;
            13:      t = 25'sd458;
            14:      t = 25'sd229;
            15:      t = 25'sd115;
            16:      t = 25'sd57;
            17:      t = 25'sd29;
            18:      t = 25'sd14;
            19:      t = 25'sd7;
            20:      t = 25'sd4;
            21:      t = 25'sd2;
            22:      t = 25'sd1;
            default: t = 25'sd0;
        endcase
        return t;
    endfunction

endpackage

/* rtl/core/tlt_sample_if.sv */
// Handshake channel carrying one three-axis acceleration sample.
interface tlt_sample_if #(
    parameter int SAMPLE_BITS = tlt_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] accel_x;
    logic [SAMPLE_BITS-1:0] accel_y;
    logic [SAMPLE_BITS-1:0] accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    output ready);
endinterface

/* rtl/core/tlt_angle_if.sv */
// Handshake channel carrying one tilt angle result.
interface tlt_angle_if;
    logic        valid;
    logic        ready;
    logic [14:0] tilt_angle;
    logic [1:0]  quadrant;

    modport source (output valid, output tilt_angle, output quadrant, input ready);
    modport sink   (input valid, input tilt_angle, input quadrant, output ready);
endinterface

/* rtl/core/tlt_front.sv */
// Input stage: quadrant choice, magnitudes and CORDIC operand setup.
module tlt_front #(
    parameter int SAMPLE_BITS = tlt_pkg::SAMPLE_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    tlt_sample_if.sink       sample,
    output logic             out_valid,
    output tlt_pkg::cordic_t out_data,
    input  logic             out_ready
);
    import tlt_pkg::*;

    localparam int GUARD = ALIGN_BITS - SAMPLE_BITS;

    logic                   x_neg, y_neg, z_neg, x_zero, y_zero;
    logic                   x_ge, x_le, y_ge, y_le;
    logic [SAMPLE_BITS-1:0] mag_x, mag_y, num, den;
    logic [1:0]             quad;
    logic                   valid_reg, valid_next;
    cordic_t                data_reg, data_next;
    logic                   load;

    // Sign and zero tests
    assign x_neg  = sample.accel_x[SAMPLE_BITS-1];
    assign y_neg  = sample.accel_y[SAMPLE_BITS-1];
    assign z_neg  = sample.accel_z[SAMPLE_BITS-1];
    assign x_zero = (sample.accel_x == '0);
    assign y_zero = (sample.accel_y == '0);
    assign x_ge   = !x_neg;
    assign y_ge   = !y_neg;
    assign x_le   = x_neg || x_zero;
    assign y_le   = y_neg || y_zero;

    // Exact magnitudes; the most negative code maps to 2^(SAMPLE_BITS-1)
    assign mag_x = x_neg ? (~sample.accel_x + 1'b1) : sample.accel_x;
    assign mag_y = y_neg ? (~sample.accel_y + 1'b1) : sample.accel_y;

    // Quadrant choice, mirrored when z is not negative; ties by test order
    always_comb
    begin
        if (z_neg)
        begin
            if (x_ge && y_ge)
                quad = QUAD_FIRST;
            else if (x_ge && y_le)
                quad = QUAD_SECOND;
            else if (x_le && y_le)
                quad = QUAD_THIRD;
            else
                quad = QUAD_FOURTH;
        end
        else
        begin
            if (x_le && y_ge)
                quad = QUAD_FIRST;
            else if (x_le && y_le)
                quad = QUAD_SECOND;
            else if (x_ge && y_le)
                quad = QUAD_THIRD;
            else
                quad = QUAD_FOURTH;
        end
    end

    // Operands swap in the second and fourth quadrants
    assign num = quad[0] ? mag_y : mag_x;
    assign den = quad[0] ? mag_x : mag_y;

    always_comb
    begin
        data_next.x        = $signed({{(CW-ALIGN_BITS){1'b0}}, den, {GUARD{1'b0}}});
        data_next.y        = $signed({{(CW-ALIGN_BITS){1'b0}}, num, {GUARD{1'b0}}});
        data_next.z        = '0;
        data_next.quad     = quad;
        data_next.num_zero = (num == '0);
        data_next.den_zero = (den == '0);
    end

    // Stage register with valid bit
    assign sample.ready = !valid_reg || out_ready;
    assign load         = sample.valid && sample.ready;
    assign valid_next   = sample.ready ? sample.valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/core/tlt_cordic_stage.sv */
// One vectoring CORDIC iteration with its pipeline register.
module tlt_cordic_stage #(
    parameter int STEP = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  tlt_pkg::cordic_t in_data,
    output logic             in_ready,
    output logic             out_valid,
    output tlt_pkg::cordic_t out_data,
    input  logic             out_ready
);
    import tlt_pkg::*;

    localparam logic signed [ZW-1:0] ANGLE = atan_step(STEP);

    logic signed [CW-1:0] sh_x, sh_y;
    logic                 valid_reg, valid_next;
    cordic_t              data_reg, data_next;
    logic                 load;

    // Floor shifts of the values from before the step
    assign sh_x = $signed(in_data.x) >>> STEP;
    assign sh_y = $signed(in_data.y) >>> STEP;

    // Rotate toward the x axis
    always_comb
    begin
        data_next = in_data;
        if (!in_data.y[CW-1])
        begin
            data_next.x = in_data.x + sh_y;
            data_next.y = in_data.y - sh_x;
            data_next.z = in_data.z + ANGLE;
        end
        else
        begin
            data_next.x = in_data.x - sh_y;
            data_next.y = in_data.y + sh_x;
            data_next.z = in_data.z - ANGLE;
        end
    end

    // Stage register with valid bit
    assign in_ready   = !valid_reg || out_ready;
    assign load       = in_valid && in_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/core/tlt_back.sv */
// Output stage: rounding, clamping, special cases and quadrant offset.
module tlt_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  tlt_pkg::cordic_t in_data,
    output logic             in_ready,
    tlt_angle_if.source      result
);
    import tlt_pkg::*;

    logic signed [ZW-1:0] z_round;
    logic signed [RW-1:0] z_deg;
    logic [AW-1:0]        inner, offset;
    logic                 valid_reg, valid_next;
    logic [AW-1:0]        angle_reg, angle_next;
    logic [1:0]           quad_reg;
    logic                 load;

    // Round half up to 1/64 degree
    assign z_round = in_data.z + ROUND_HALF;
    assign z_deg   = z_round[ZW-1:10];

    // Clamp between zero and a quarter turn; zero operands are exact
    always_comb
    begin
        if (in_data.num_zero)
            inner = '0;
        else if (in_data.den_zero)
            inner = QUARTER_TURN;
        else if (z_deg[RW-1])
            inner = '0;
        else if (AW'(z_deg) > QUARTER_TURN)
            inner = QUARTER_TURN;
        else
            inner = AW'(z_deg);
    end

    // Quadrant offset
    always_comb
    begin
        case (in_data.quad)
            QUAD_FIRST:  offset = '0;
            QUAD_SECOND: offset = QUARTER_TURN;
            QUAD_THIRD:  offset = AW'(2 * 5760);
            QUAD_FOURTH: offset = AW'(3 * 5760);
            default:     offset = '0;
        endcase
    end

    assign angle_next = inner + offset;

    // Output register
    assign in_ready   = !valid_reg || result.ready;
    assign load       = in_valid && in_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            angle_reg <= angle_next;
            quad_reg  <= in_data.quad;
        end
    end

    assign result.valid      = valid_reg;
    assign result.tilt_angle = angle_reg;
    assign result.quadrant   = quad_reg;

endmodule

/* rtl/core/tilt_angle_from_acceleration.sv */
// Top level of the accelerometer tilt angle pipeline.
// Takes one signed (x, y, z) acceleration sample per transaction and returns
// the tilt angle in 1/64 degree (0 to 360 degrees) with the chosen quadrant.
// The signs of x and y pick the quadrant, mirrored when z is not negative;
// the angle inside it is a vectoring CORDIC atan2 of the two magnitudes plus
// a 90 degree step per quadrant. Throughput is one transaction per clock
// while the output takes results. The path holds one input stage, one
// register per CORDIC iteration and one output register. Every stage has
// its own valid bit and loads whenever it is empty or its successor takes
// its content, so bubbles close up and a stalled output does not stop the
// upstream stages until they fill.
module tilt_angle_from_acceleration #(
    parameter int SAMPLE_BITS  = tlt_pkg::SAMPLE_BITS_DEF,
    parameter int CORDIC_STEPS = tlt_pkg::CORDIC_STEPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tlt_sample_if.sink  sample,
    tlt_angle_if.source result
);
    import tlt_pkg::*;

    logic    st_valid [CORDIC_STEPS+1];
    logic    st_ready [CORDIC_STEPS+1];
    cordic_t st_data  [CORDIC_STEPS+1];

    // Operand setup
    tlt_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .out_valid (st_valid[0]),
        .out_data  (st_data[0]),
        .out_ready (st_ready[0])
    );

    // CORDIC iterations, one register stage each
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        tlt_cordic_stage #(
            .STEP (i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (st_valid[i]),
            .in_data   (st_data[i]),
            .in_ready  (st_ready[i]),
            .out_valid (st_valid[i+1]),
            .out_data  (st_data[i+1]),
            .out_ready (st_ready[i+1])
        );
    end

    // Final angle and output register
    tlt_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (st_valid[CORDIC_STEPS]),
        .in_data  (st_data[CORDIC_STEPS]),
        .in_ready (st_ready[CORDIC_STEPS]),
        .result   (result)
    );

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the tilt angle pipeline: directed and random samples.
`timescale 1ns / 100ps

module tb_top;

    import tlt_pkg::*;

    localparam int SAMPLE_BITS  = SAMPLE_BITS_DEF;
    localparam int CORDIC_STEPS = CORDIC_STEPS_DEF;
    localparam int PIPE_LATENCY = CORDIC_STEPS + 2;
    localparam int GUARD_SHIFT  = ALIGN_BITS - SAMPLE_BITS;
    localparam int SAMPLE_MAX   = (1 << (SAMPLE_BITS - 1)) - 1;
    localparam int SAMPLE_MIN   = -(1 << (SAMPLE_BITS - 1));
    localparam int RANDOM_ITEMS = 1540;
    // Watchdog limit in ns, well beyond the slowest legal run
    localparam longint TIMEOUT_NS = 64'd20_000_000;

    // atan(2^-i) in 1/65536 degree
    localparam longint ATAN_LUT [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct {
        logic [AW-1:0] tilt_angle;
        logic [1:0]    quadrant;
    } tilt_result_t;

    logic clk;
    logic rst_n;

    tlt_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
    tlt_angle_if result_ch ();

    tilt_angle_from_acceleration #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch)
    );

    tilt_result_t expected_tilts [$];
    int unsigned  mismatch_count = 0;
    bit           src_idle_en    = 1'b0;
    bit           sink_idle_en   = 1'b0;
    int unsigned  sink_hold_req  = 0;

    // Clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Idle length: mostly none, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Vectoring CORDIC atan2(a, b), a and b not negative, in 1/64 degree
    function automatic longint cordic_atan2(longint a, longint b);
        longint xv;
        longint yv;
        longint zv;
        longint dx;
        longint dy;
        int     i;
        if (a == 0)
            return 0;
        if (b == 0)
            return longint'(QUARTER_TURN);
        xv = b <<< GUARD_SHIFT;
        yv = a <<< GUARD_SHIFT;
        zv = 0;
        for (i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv >= 0)
            begin
                xv = xv + dx;
                yv = yv - dy;
                zv = zv + ATAN_LUT[i];
            end
            else
            begin
                xv = xv - dx;
                yv = yv + dy;
                zv = zv - ATAN_LUT[i];
            end
        end
        zv = (zv + 512) >>> 10;
        if (zv < 0)
            zv = 0;
        if (zv > longint'(QUARTER_TURN))
            zv = longint'(QUARTER_TURN);
        return zv;
    endfunction

    // Quadrant from signs (mirrored for z not negative), then angle plus offset
    function automatic tilt_result_t predict_tilt(logic signed [SAMPLE_BITS-1:0] ax,
                                                  logic signed [SAMPLE_BITS-1:0] ay,
                                                  logic signed [SAMPLE_BITS-1:0] az);
        longint       sx;
        longint       sy;
        longint       sz;
        longint       mx;
        longint       my;
        longint       ang;
        logic [1:0]   q;
        tilt_result_t res;
        sx = ax;
        sy = ay;
        sz = az;
        mx = (sx < 0) ? -sx : sx;
        my = (sy < 0) ? -sy : sy;
        if (sz < 0)
        begin
            if (sx >= 0 && sy >= 0)
                q = QUAD_FIRST;
            else if (sx >= 0 && sy <= 0)
                q = QUAD_SECOND;
            else if (sx <= 0 && sy <= 0)
                q = QUAD_THIRD;
            else
                q = QUAD_FOURTH;
        end
        else
        begin
            if (sx <= 0 && sy >= 0)
                q = QUAD_FIRST;
            else if (sx <= 0 && sy <= 0)
                q = QUAD_SECOND;
            else if (sx >= 0 && sy <= 0)
                q = QUAD_THIRD;
            else
                q = QUAD_FOURTH;
        end
        if (q == QUAD_FIRST || q == QUAD_THIRD)
            ang = cordic_atan2(mx, my);
        else
            ang = cordic_atan2(my, mx);
        ang = ang + longint'(q) * longint'(QUARTER_TURN);
        res.tilt_angle = ang[AW-1:0];
        res.quadrant   = q;
        return res;
    endfunction

    // Axis value biased toward zero, extremes and small magnitudes
    function automatic int rand_axis();
        int v;
        case ($urandom_range(0, 11))
            0:       v = 0;
            1:       v = SAMPLE_MIN;
            2:       v = SAMPLE_MAX;
            3:       v = $urandom_range(0, 30) - 15;
            4:       v = ($urandom_range(0, 1) != 0) ? 1 : -1;
            default: v = $signed(SAMPLE_BITS'($urandom));
        endcase
        return v;
    endfunction

    // Send one sample; entered and left right after a rising edge
    task automatic send_sample(int x, int y, int z);
        logic [SAMPLE_BITS-1:0] bx;
        logic [SAMPLE_BITS-1:0] by;
        logic [SAMPLE_BITS-1:0] bz;
        int unsigned            gap;
        bx = x[SAMPLE_BITS-1:0];
        by = y[SAMPLE_BITS-1:0];
        bz = z[SAMPLE_BITS-1:0];
        sample_ch.valid   <= 1'b1;
        sample_ch.accel_x <= bx;
        sample_ch.accel_y <= by;
        sample_ch.accel_z <= bz;
        // ready is stable between edges; check it mid-cycle
        @(negedge clk);
        while (!sample_ch.ready)
            @(negedge clk);
        @(posedge clk);
        expected_tilts.push_back(predict_tilt(bx, by, bz));
        gap = src_idle_en ? pick_gap() : 0;
        if (gap != 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every outstanding result has arrived
    task automatic wait_for_results();
        sample_ch.valid <= 1'b0;
        while (expected_tilts.size() != 0)
            @(posedge clk);
    endtask

    // Output side pacing; a pending hold request is served first
    initial
    begin : sink_pacing
        int unsigned hold;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (sink_hold_req != 0)
            begin
                hold          = sink_hold_req;
                sink_hold_req = 0;
            end
            else if (sink_idle_en)
                hold = pick_gap();
            else
                hold = 0;
            result_ch.ready <= (hold == 0);
            if (hold > 1)
                repeat (hold - 1) @(posedge clk);
        end
    end

    // Compare each result transaction with the oldest prediction
    initial
    begin : result_checker
        tilt_result_t head;
        forever
        begin
            @(negedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                if (expected_tilts.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got angle %0d quadrant %0d",
                             $time, result_ch.tilt_angle, result_ch.quadrant);
                    mismatch_count++;
                end
                else
                begin
                    head = expected_tilts.pop_front();
                    if (result_ch.tilt_angle !== head.tilt_angle)
                    begin
                        $display("%0t: tilt_angle mismatch, expected %0d, got %0d",
                                 $time, head.tilt_angle, result_ch.tilt_angle);
                        mismatch_count++;
                    end
                    if (result_ch.quadrant !== head.quadrant)
                    begin
                        $display("%0t: quadrant mismatch, expected %0d, got %0d",
                                 $time, head.quadrant, result_ch.quadrant);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Zero operands, axis ties, extremes and equal magnitudes, both z signs
    task automatic test_axis_and_sign_cases();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        send_sample(0, 0, -1);
        send_sample(0, 0, 0);
        send_sample(SAMPLE_MAX, 0, -1);
        send_sample(0, SAMPLE_MAX, -1);
        send_sample(SAMPLE_MIN, 0, -1);
        send_sample(0, SAMPLE_MIN, -1);
        send_sample(SAMPLE_MAX, 0, 0);
        send_sample(0, SAMPLE_MAX, 0);
        send_sample(SAMPLE_MIN, 0, 0);
        send_sample(0, SAMPLE_MIN, 0);
        send_sample(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
        send_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
        send_sample(SAMPLE_MIN, SAMPLE_MAX, -1);
        send_sample(SAMPLE_MAX, SAMPLE_MIN, 0);
        send_sample(1, 1, -1);
        send_sample(-1, -1, 0);
        send_sample(1000, -1000, SAMPLE_MIN);
        send_sample(-1000, 1000, SAMPLE_MAX);
        send_sample(1, SAMPLE_MAX, -1);
        send_sample(SAMPLE_MAX, 1, 0);
        send_sample(-5, 3, -1);
        send_sample(7, -2, 0);
        wait_for_results();
    endtask

    // Random samples; idling switched off in stretches on each side
    task automatic test_random_samples();
        int n;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            src_idle_en  = ((n / 300) % 3) != 2;
            sink_idle_en = ((n / 250) % 3) != 1;
            send_sample(rand_axis(), rand_axis(), rand_axis());
        end
        wait_for_results();
    endtask

    // Long output stall while samples keep coming, so the pipe fills up
    task automatic test_output_backpressure();
        int n;
        src_idle_en   = 1'b0;
        sink_idle_en  = 1'b0;
        sink_hold_req = 150;
        for (n = 0; n < 80; n++)
            send_sample(rand_axis(), rand_axis(), rand_axis());
        sink_idle_en = 1'b1;
        for (n = 0; n < 40; n++)
            send_sample(rand_axis(), rand_axis(), rand_axis());
        wait_for_results();
    endtask

    // Empty pipe between bursts, then resume
    task automatic test_drain_then_resume();
        int n;
        int k;
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        for (k = 0; k < 4; k++)
        begin
            for (n = 0; n < 30; n++)
                send_sample(rand_axis(), rand_axis(), rand_axis());
            wait_for_results();
            repeat ($urandom_range(1, PIPE_LATENCY)) @(posedge clk);
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n             = 1'b0;
        sample_ch.valid   = 1'b0;
        sample_ch.accel_x = '0;
        sample_ch.accel_y = '0;
        sample_ch.accel_z = '0;
        result_ch.ready   = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_axis_and_sign_cases();
        test_random_samples();
        test_output_backpressure();
        test_drain_then_resume();

        wait_for_results();
        repeat (PIPE_LATENCY + 8) @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
